@@ hw/rtl/tcc_pkg.sv @@
// Shared types and constants of the text console cursor engine.
`timescale 1ns / 1ps

package tcc_pkg;

	// Screen geometry limits and the size of the character store.
	localparam int MAX_COLS   = 80;
	localparam int MAX_ROWS   = 25;
	localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;

	// Field widths.
	localparam int COL_W    = 7;
	localparam int ROW_W    = 5;
	localparam int REQROW_W = 6;
	localparam int IDX_W    = 11;
	localparam int TAB_W    = 5;
	localparam int CFG_W    = 7;
	localparam int CFGIDX_W = 2;
	localparam int PROD_W   = COL_W + ROW_W;

	// Register reset values.
	localparam logic [COL_W-1:0] WIDTH_RESET  = COL_W'(MAX_COLS);
	localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(MAX_ROWS);
	localparam logic [TAB_W-1:0] TAB_RESET    = TAB_W'(8);

	// Register indexes of the configuration port.
	localparam logic [CFGIDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFGIDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [CFGIDX_W-1:0] REG_TAB_SIZE      = 2'd2;

	// Character codes.
	localparam logic [7:0] CH_TAB      = 8'd9;
	localparam logic [7:0] CH_LF       = 8'd10;
	localparam logic [7:0] CH_CR       = 8'd13;
	localparam logic [7:0] PRINT_LO    = 8'd32;
	localparam logic [7:0] PRINT_HI    = 8'd127;
	localparam logic [7:0] BLANK_CHAR  = 8'd32;
	localparam logic [7:0] BLANK_COLOUR = 8'd2;

	// The remainder unit retires one dividend bit per cycle.
	localparam int TAB_STEPS = COL_W;
	localparam int TCNT_W    = $clog2(TAB_STEPS);

	typedef enum logic [1:0] {
		ACT_PUT   = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_SET   = 2'd2,
		ACT_READ  = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_PUT,
		S_TAB,
		S_TAB_FIX,
		S_SETTLE,
		S_SCROLL,
		S_CLEAR,
		S_SET,
		S_READ,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic put_print;
		logic put_lf;
		logic put_cr;
		logic tab_start;
		logic tab_step;
		logic tab_apply;
		logic settle;
		logic set_cursor;
		logic home;
		logic sweep;
		logic sweep_copy;
		logic sweep_all;
		logic read_issue;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_print;
		logic is_lf;
		logic is_cr;
		logic is_tab;
		logic tab_last;
		logic need_scroll;
		logic sweep_last;
		logic out_free;
	} stat_t;

endpackage

@@ hw/rtl/text_console_cursor_engine.sv @@
// Top level of the text console cursor engine: controller, datapath and checks.
`timescale 1ns / 1ps
// Each item runs from acceptance through its controller steps: printable bytes and line feed
// pass a settle step, a tab first runs the 7-step remainder unit, and a clear sweeps all
// width*height cells; a scroll sweeps every visible cell, one cell per cycle, on the store's
// separate read and write ports. The result beat is loaded once the output register is free.
// After reset a clearing pass over the whole store blanks it, taking configuration writes but
// no beat. Reset clears all control state.

module text_console_cursor_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  logic [1:0]                      action,
	input  logic [7:0]                      char_code,
	input  logic [tcc_pkg::COL_W-1:0]       col,
	input  logic [tcc_pkg::REQROW_W-1:0]    row,
	input  logic [tcc_pkg::IDX_W-1:0]       cell_index,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [tcc_pkg::COL_W-1:0]       cursor_col,
	output logic [tcc_pkg::ROW_W-1:0]       cursor_row,
	output logic [tcc_pkg::IDX_W-1:0]       cursor_pos,
	output logic [7:0]                      read_char,
	output logic [7:0]                      read_colour,
	output logic                            scrolled,
	input  logic                            cfg_we,
	input  logic [tcc_pkg::CFGIDX_W-1:0]    cfg_index,
	input  logic [tcc_pkg::CFG_W-1:0]       cfg_data
);
	import tcc_pkg::*;

	// The controller walks each item through its steps and the datapath does the
	// arithmetic and store accesses. They meet only through these two structs.
	cmd_t  cmd;
	stat_t stat;

	tcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.action    (action),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the output register, so a finished beat can wait for
	// the consumer while the next item is already accepted and worked on.
	tcc_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.char_code   (char_code),
		.col         (col),
		.row         (row),
		.cell_index  (cell_index),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.rsp_ready   (rsp_ready),
		.rsp_valid   (rsp_valid),
		.cursor_col  (cursor_col),
		.cursor_row  (cursor_row),
		.cursor_pos  (cursor_pos),
		.read_char   (read_char),
		.read_colour (read_colour),
		.scrolled    (scrolled)
	);

	// A new result is only loaded when the output register is free or draining.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp_valid || rsp_ready))
		else $error("result loaded over an undelivered beat");

	// A scroll always leaves the cursor at the start of a row.
	a_scroll_home: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && scrolled) |-> (cursor_col == '0))
		else $error("scroll did not home the cursor column");

	// Stored characters are never zero, so a read hit and its colour go together.
	a_read_pair: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((read_char == 8'd0) == (read_colour == 8'd0)))
		else $error("read character and colour disagree");

	// The reported cursor always lies on the largest screen.
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((cursor_col < COL_W'(MAX_COLS)) && (cursor_row < ROW_W'(MAX_ROWS))))
		else $error("reported cursor outside the screen");

endmodule

@@ hw/rtl/tcc_ctrl.sv @@
// Controller state machine of the text console cursor engine.
`timescale 1ns / 1ps

module tcc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  logic [1:0]           action,
	input  tcc_pkg::stat_t       stat,
	output tcc_pkg::cmd_t        cmd
);
	import tcc_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_INIT: begin
				cmd.sweep     = 1'b1;
				cmd.sweep_all = 1'b1;
				if (stat.sweep_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.accept = 1'b1;
					case (action_t'(action))
						ACT_PUT:   state_nxt = S_PUT;
						ACT_CLEAR: state_nxt = S_CLEAR;
						ACT_SET:   state_nxt = S_SET;
						ACT_READ:  state_nxt = S_READ;
						default:   state_nxt = S_IDLE;
					endcase
				end
			end
			S_PUT: begin
				if (stat.is_print) begin
					cmd.put_print = 1'b1;
					state_nxt     = S_SETTLE;
				end else if (stat.is_lf) begin
					cmd.put_lf = 1'b1;
					state_nxt  = S_SETTLE;
				end else if (stat.is_cr) begin
					cmd.put_cr = 1'b1;
					state_nxt  = S_FINISH;
				end else if (stat.is_tab) begin
					cmd.tab_start = 1'b1;
					state_nxt     = S_TAB;
				end else begin
					state_nxt = S_FINISH;
				end
			end
			S_TAB: begin
				cmd.tab_step = 1'b1;
				if (stat.tab_last) begin
					state_nxt = S_TAB_FIX;
				end
			end
			S_TAB_FIX: begin
				cmd.tab_apply = 1'b1;
				state_nxt     = S_SETTLE;
			end
			S_SETTLE: begin
				cmd.settle = 1'b1;
				state_nxt  = stat.need_scroll ? S_SCROLL : S_FINISH;
			end
			S_SCROLL: begin
				cmd.sweep      = 1'b1;
				cmd.sweep_copy = 1'b1;
				if (stat.sweep_last) begin
					state_nxt = S_FINISH;
				end
			end
			S_CLEAR: begin
				cmd.sweep = 1'b1;
				cmd.home  = 1'b1;
				if (stat.sweep_last) begin
					state_nxt = S_FINISH;
				end
			end
			S_SET: begin
				cmd.set_cursor = 1'b1;
				state_nxt      = S_FINISH;
			end
			S_READ: begin
				cmd.read_issue = 1'b1;
				state_nxt      = S_FINISH;
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/tcc_datapath.sv @@
// Datapath of the text console cursor engine: registers, cursor, store and output.
`timescale 1ns / 1ps

module tcc_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tcc_pkg::cmd_t                   cmd,
	output tcc_pkg::stat_t                  stat,
	input  logic [7:0]                      char_code,
	input  logic [tcc_pkg::COL_W-1:0]       col,
	input  logic [tcc_pkg::REQROW_W-1:0]    row,
	input  logic [tcc_pkg::IDX_W-1:0]       cell_index,
	input  logic                            cfg_we,
	input  logic [tcc_pkg::CFGIDX_W-1:0]    cfg_index,
	input  logic [tcc_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            rsp_ready,
	output logic                            rsp_valid,
	output logic [tcc_pkg::COL_W-1:0]       cursor_col,
	output logic [tcc_pkg::ROW_W-1:0]       cursor_row,
	output logic [tcc_pkg::IDX_W-1:0]       cursor_pos,
	output logic [7:0]                      read_char,
	output logic [7:0]                      read_colour,
	output logic                            scrolled
);
	import tcc_pkg::*;

	// Configuration registers.
	logic [COL_W-1:0] width_q;
	logic [ROW_W-1:0] height_q;
	logic [TAB_W-1:0] tab_q;

	// Latched item fields.
	logic [7:0]          char_q;
	logic [COL_W-1:0]    req_col_q;
	logic [REQROW_W-1:0] req_row_q;
	logic [IDX_W-1:0]    cidx_q;

	// Cursor and per-item flags.
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             scrolled_q;
	logic             hit_q;

	// Remainder unit for tab stops.
	logic [TAB_W-1:0]  rem_q;
	logic [COL_W-1:0]  dvd_q;
	logic [TCNT_W-1:0] tcnt_q;

	// Sweep counter and its write stage.
	logic [IDX_W-1:0] sweep_q;
	logic             wr_valid_s1;
	logic             copy_s1;
	logic [IDX_W-1:0] wr_addr_s1;

	// Character store; every cell holds the blank colour, so only characters are kept.
	logic [7:0] mem [CELL_COUNT];
	logic [7:0] rd_data_q;

	// Output register.
	logic             out_valid_q;
	logic [COL_W-1:0] out_col_q;
	logic [ROW_W-1:0] out_row_q;
	logic [IDX_W-1:0] out_pos_q;
	logic [7:0]       out_char_q;
	logic [7:0]       out_colour_q;
	logic             out_scr_q;

	logic [PROD_W-1:0] cells;
	logic [PROD_W-1:0] cur_lin;
	logic [PROD_W-1:0] sweep_end;
	logic [PROD_W-1:0] src_addr;
	logic              copy_now;
	logic              wrap;
	logic [COL_W-1:0]  wrap_col;
	logic [ROW_W:0]    wrap_row;
	logic [TAB_W:0]    partial;
	logic              sub_ok;
	logic [TAB_W:0]    partial_sub;
	logic [COL_W:0]    tab_col;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [7:0]        mem_wdata;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;
	logic [COL_W-1:0]  new_width;
	logic [ROW_W-1:0]  new_height;
	logic [TAB_W-1:0]  new_tab;

	// Clamp written register values into their legal ranges.
	always_comb begin
		if (cfg_data == '0) begin
			new_width = COL_W'(1);
		end else if (cfg_data > WIDTH_RESET) begin
			new_width = WIDTH_RESET;
		end else begin
			new_width = cfg_data;
		end
		if (cfg_data[ROW_W-1:0] == '0) begin
			new_height = ROW_W'(1);
		end else if (cfg_data[ROW_W-1:0] > HEIGHT_RESET) begin
			new_height = HEIGHT_RESET;
		end else begin
			new_height = cfg_data[ROW_W-1:0];
		end
		new_tab = (cfg_data[TAB_W-1:0] == '0) ? TAB_W'(1) : cfg_data[TAB_W-1:0];
	end

	assign cells     = PROD_W'(width_q * height_q);
	assign cur_lin   = PROD_W'(row_q * width_q) + PROD_W'(col_q);
	assign sweep_end = cmd.sweep_all ? PROD_W'(CELL_COUNT) : cells;
	assign src_addr  = PROD_W'(sweep_q) + PROD_W'(width_q);
	assign copy_now  = cmd.sweep_copy && (src_addr < cells);

	// Wrap past the last column, then test for a scroll.
	assign wrap     = (col_q >= width_q);
	assign wrap_col = wrap ? '0 : col_q;
	assign wrap_row = {1'b0, row_q} + (ROW_W+1)'(wrap);

	// One restoring step of col mod tab_size.
	assign partial     = {rem_q, dvd_q[COL_W-1]};
	assign sub_ok      = (partial >= {1'b0, tab_q});
	assign partial_sub = partial - {1'b0, tab_q};
	assign tab_col     = {1'b0, col_q} + (COL_W+1)'(tab_q) - (COL_W+1)'(rem_q);

	always_comb begin
		stat.is_print    = (char_q inside {[PRINT_LO:PRINT_HI]});
		stat.is_lf       = (char_q == CH_LF);
		stat.is_cr       = (char_q == CH_CR);
		stat.is_tab      = (char_q == CH_TAB);
		stat.tab_last    = (tcnt_q == TCNT_W'(TAB_STEPS - 1));
		stat.need_scroll = (wrap_row >= {1'b0, height_q});
		stat.sweep_last  = (PROD_W'(sweep_q) == sweep_end - PROD_W'(1));
		stat.out_free    = !out_valid_q || rsp_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			char_q    <= char_code;
			req_col_q <= col;
			req_row_q <= row;
			cidx_q    <= cell_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
			tab_q    <= TAB_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH:  width_q  <= new_width;
				REG_SCREEN_HEIGHT: height_q <= new_height;
				REG_TAB_SIZE:      tab_q    <= new_tab;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we && cfg_index == REG_SCREEN_WIDTH) begin
			if (col_q >= new_width) begin
				col_q <= new_width - COL_W'(1);
			end
		end else if (cfg_we && cfg_index == REG_SCREEN_HEIGHT) begin
			if (row_q >= new_height) begin
				row_q <= new_height - ROW_W'(1);
			end
		end else if (cmd.put_print) begin
			col_q <= col_q + COL_W'(1);
		end else if (cmd.put_lf) begin
			row_q <= row_q + ROW_W'(1);
		end else if (cmd.put_cr) begin
			col_q <= '0;
		end else if (cmd.tab_apply) begin
			col_q <= tab_col[COL_W-1:0];
		end else if (cmd.settle) begin
			if (stat.need_scroll) begin
				col_q <= '0;
				row_q <= height_q - ROW_W'(1);
			end else begin
				col_q <= wrap_col;
				row_q <= wrap_row[ROW_W-1:0];
			end
		end else if (cmd.set_cursor) begin
			col_q <= (req_col_q >= width_q) ? width_q - COL_W'(1) : req_col_q;
			row_q <= (req_row_q >= {1'b0, height_q}) ? height_q - ROW_W'(1)
			                                          : req_row_q[ROW_W-1:0];
		end else if (cmd.home) begin
			col_q <= '0;
			row_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scrolled_q <= 1'b0;
			hit_q      <= 1'b0;
		end else if (cmd.accept) begin
			scrolled_q <= 1'b0;
			hit_q      <= 1'b0;
		end else begin
			if (cmd.settle && stat.need_scroll) begin
				scrolled_q <= 1'b1;
			end
			if (cmd.read_issue) begin
				hit_q <= (PROD_W'(cidx_q) < cells);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dvd_q  <= '0;
			tcnt_q <= '0;
		end else if (cmd.tab_start) begin
			rem_q  <= '0;
			dvd_q  <= col_q;
			tcnt_q <= '0;
		end else if (cmd.tab_step) begin
			rem_q  <= sub_ok ? partial_sub[TAB_W-1:0] : partial[TAB_W-1:0];
			dvd_q  <= {dvd_q[COL_W-2:0], 1'b0};
			tcnt_q <= tcnt_q + TCNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			wr_valid_s1 <= 1'b0;
		end else begin
			if (cmd.accept) begin
				sweep_q <= '0;
			end else if (cmd.sweep) begin
				sweep_q <= stat.sweep_last ? '0 : sweep_q + IDX_W'(1);
			end
			wr_valid_s1 <= cmd.sweep;
		end
	end

	always_ff @(posedge clk) begin
		copy_s1    <= copy_now;
		wr_addr_s1 <= sweep_q;
	end

	// Store ports: the sweep write stage owns the write port while it runs.
	assign mem_we    = wr_valid_s1 || cmd.put_print;
	assign mem_waddr = wr_valid_s1 ? wr_addr_s1 : cur_lin[IDX_W-1:0];
	assign mem_wdata = wr_valid_s1 ? (copy_s1 ? rd_data_q : BLANK_CHAR) : char_q;
	assign mem_re    = cmd.read_issue || (cmd.sweep && copy_now);
	assign mem_raddr = cmd.read_issue ? cidx_q : src_addr[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_col_q    <= col_q;
			out_row_q    <= row_q;
			out_pos_q    <= cur_lin[IDX_W-1:0];
			out_char_q   <= hit_q ? rd_data_q : 8'd0;
			out_colour_q <= hit_q ? BLANK_COLOUR : 8'd0;
			out_scr_q    <= scrolled_q;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign cursor_col  = out_col_q;
	assign cursor_row  = out_row_q;
	assign cursor_pos  = out_pos_q;
	assign read_char   = out_char_q;
	assign read_colour = out_colour_q;
	assign scrolled    = out_scr_q;

endmodule
